@@ design/tcsp_pkg.sv @@
// shared types, constants and fixed-point helpers for the triangle geometry engine
package tcsp_pkg;

  typedef struct packed {
    logic signed [31:0] vert0_x, vert0_y, vert0_z;
    logic signed [31:0] vert1_x, vert1_y, vert1_z;
    logic signed [31:0] vert2_x, vert2_y, vert2_z;
  } item_t;

  typedef struct packed {
    logic               visible;
    logic signed [31:0] screen0_x, screen0_y;
    logic signed [31:0] screen1_x, screen1_y;
    logic signed [31:0] screen2_x, screen2_y;
    logic signed [31:0] depth_sum;
    logic [3:0]         shade_level;
  } result_t;

  typedef struct packed {
    logic signed [31:0] rot_z_cos, rot_z_sin, rot_x_cos, rot_x_sin;
    logic signed [31:0] proj_x_scale, proj_y_scale, proj_z_scale, proj_z_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] x, y, z;
  } vec_t;

  typedef struct packed {
    logic visible;
    vec_t v0, v1, v2;
    vec_t n;
  } tri_t;

  typedef enum logic [2:0] {
    REG_ROT_Z_COS, REG_ROT_Z_SIN, REG_ROT_X_COS, REG_ROT_X_SIN,
    REG_PROJ_X_SCALE, REG_PROJ_Y_SCALE, REG_PROJ_Z_SCALE, REG_PROJ_Z_OFFSET
  } cfg_reg_t;

  localparam cfg_t CFG_RESET = '{
    rot_z_cos: 32'sd65536, rot_z_sin: 32'sd0, rot_x_cos: 32'sd65536, rot_x_sin: 32'sd0,
    proj_x_scale: 32'sd65536, proj_y_scale: 32'sd65536,
    proj_z_scale: 32'sd65543, proj_z_offset: -32'sd6554
  };

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
  localparam logic signed [63:0] Z_SHIFT = 64'sd524288;
  localparam logic signed [63:0] ONE_Q   = 64'sd65536;

  localparam int DIV_BITS  = 48;
  localparam int DIV_LAT   = DIV_BITS + 2;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;
  localparam int SHADE_MAX = 12;
  localparam int SHADE_K   = 13;

  function automatic logic signed [47:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S32_MAX) return S32_MAX[31:0];
    else if (v < S32_MIN) return S32_MIN[31:0];
    else return v[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic signed [31:0] neg;
    neg = -v;
    return v[31] ? neg : v;
  endfunction

endpackage

@@ design/tcsp_fifo.sv @@
// small register queue with full and empty flags
module tcsp_fifo #(
  parameter type T = logic,
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);
  localparam int AW = $clog2(DEPTH);

  T mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic          do_push, do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end
endmodule

@@ design/tcsp_front.sv @@
// front pipeline: rotation, translation, face normal and back-face classification
module tcsp_front (
  input  logic            clk,
  input  logic            rst,
  input  tcsp_pkg::cfg_t  cfg,
  input  logic            in_valid,
  input  tcsp_pkg::item_t in_item,
  output logic            ready,
  input  logic            out_full,
  output logic            out_push,
  output tcsp_pkg::tri_t  out_tri
);
  logic adv;
  logic [7:0] vld;

  logic signed [31:0] ix [3], iy [3], iz [3];
  logic signed [47:0] s1_a [3], s1_b [3], s1_c [3], s1_d [3];
  logic signed [31:0] s1_z [3];
  logic signed [31:0] s2_x [3], s2_y [3], s2_z [3];
  logic signed [47:0] s3_a [3], s3_b [3], s3_c [3], s3_d [3];
  logic signed [31:0] s3_x [3];
  logic signed [31:0] s4_v [3][3];
  logic signed [31:0] s5_v [3][3];
  logic signed [31:0] s5_e1 [3], s5_e2 [3];
  logic signed [31:0] s6_v [3][3];
  logic signed [47:0] s6_p [3], s6_q [3];
  logic signed [31:0] s7_v [3][3];
  logic signed [31:0] s7_n [3];
  logic signed [31:0] s8_v [3][3];
  logic signed [31:0] s8_n [3];
  logic signed [63:0] s8_dp [3];
  logic               s8_degen;
  logic signed [31:0] zsum [3];
  logic signed [65:0] dot;

  assign adv      = !out_full;
  assign ready    = adv;
  assign out_push = adv && vld[7];

  always_comb begin
    ix[0] = in_item.vert0_x; iy[0] = in_item.vert0_y; iz[0] = in_item.vert0_z;
    ix[1] = in_item.vert1_x; iy[1] = in_item.vert1_y; iz[1] = in_item.vert1_z;
    ix[2] = in_item.vert2_x; iy[2] = in_item.vert2_y; iz[2] = in_item.vert2_z;
    for (int i = 0; i < 3; i++) begin
      zsum[i] = tcsp_pkg::sat32(64'(s3_c[i]) + 64'(s3_d[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_a[i] <= tcsp_pkg::qmul(ix[i], cfg.rot_z_cos);
        s1_b[i] <= tcsp_pkg::qmul(iy[i], cfg.rot_z_sin);
        s1_c[i] <= tcsp_pkg::qmul(ix[i], cfg.rot_z_sin);
        s1_d[i] <= tcsp_pkg::qmul(iy[i], cfg.rot_z_cos);
        s1_z[i] <= iz[i];

        s2_x[i] <= tcsp_pkg::sat32(64'(s1_a[i]) - 64'(s1_b[i]));
        s2_y[i] <= tcsp_pkg::sat32(64'(s1_c[i]) + 64'(s1_d[i]));
        s2_z[i] <= s1_z[i];

        s3_a[i] <= tcsp_pkg::qmul(s2_y[i], cfg.rot_x_cos);
        s3_b[i] <= tcsp_pkg::qmul(s2_z[i], cfg.rot_x_sin);
        s3_c[i] <= tcsp_pkg::qmul(s2_y[i], cfg.rot_x_sin);
        s3_d[i] <= tcsp_pkg::qmul(s2_z[i], cfg.rot_x_cos);
        s3_x[i] <= s2_x[i];

        s4_v[i][0] <= s3_x[i];
        s4_v[i][1] <= tcsp_pkg::sat32(64'(s3_a[i]) - 64'(s3_b[i]));
        s4_v[i][2] <= tcsp_pkg::sat32(64'(zsum[i]) + tcsp_pkg::Z_SHIFT);

        s5_e1[i] <= tcsp_pkg::sat32(64'(s4_v[1][i]) - 64'(s4_v[0][i]));
        s5_e2[i] <= tcsp_pkg::sat32(64'(s4_v[2][i]) - 64'(s4_v[0][i]));
        for (int j = 0; j < 3; j++) begin
          s5_v[i][j] <= s4_v[i][j];
          s6_v[i][j] <= s5_v[i][j];
          s7_v[i][j] <= s6_v[i][j];
          s8_v[i][j] <= s7_v[i][j];
        end

        s7_n[i]  <= tcsp_pkg::sat32(64'(s6_p[i]) - 64'(s6_q[i]));
        s8_n[i]  <= s7_n[i];
        s8_dp[i] <= 64'(s7_n[i]) * 64'(s7_v[0][i]);
      end
      s6_p[0] <= tcsp_pkg::qmul(s5_e1[1], s5_e2[2]);
      s6_q[0] <= tcsp_pkg::qmul(s5_e1[2], s5_e2[1]);
      s6_p[1] <= tcsp_pkg::qmul(s5_e1[2], s5_e2[0]);
      s6_q[1] <= tcsp_pkg::qmul(s5_e1[0], s5_e2[2]);
      s6_p[2] <= tcsp_pkg::qmul(s5_e1[0], s5_e2[1]);
      s6_q[2] <= tcsp_pkg::qmul(s5_e1[1], s5_e2[0]);
      s8_degen <= (s7_n[0] == '0) && (s7_n[1] == '0) && (s7_n[2] == '0);
    end
  end

  // exact sign of dot(n, v0)
  assign dot = 66'(s8_dp[0]) + 66'(s8_dp[1]) + 66'(s8_dp[2]);

  always_comb begin
    out_tri.visible = !s8_degen && dot[65];
    out_tri.v0 = '{x: s8_v[0][0], y: s8_v[0][1], z: s8_v[0][2]};
    out_tri.v1 = '{x: s8_v[1][0], y: s8_v[1][1], z: s8_v[1][2]};
    out_tri.v2 = '{x: s8_v[2][0], y: s8_v[2][1], z: s8_v[2][2]};
    out_tri.n  = '{x: s8_n[0], y: s8_n[1], z: s8_n[2]};
  end
endmodule

@@ design/tcsp_div.sv @@
// pipelined q16.16 divider, one quotient bit per stage, saturating, zero divisor passes through
module tcsp_div (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic signed [31:0] quo
);
  localparam int NB = tcsp_pkg::DIV_BITS;

  logic [31:0]        d_q    [NB+1];
  logic [31:0]        r_q    [NB+1];
  logic [NB-1:0]      n_q    [NB+1];
  logic [NB-1:0]      q_q    [NB+1];
  logic               neg_q  [NB+1];
  logic               zero_q [NB+1];
  logic signed [31:0] pass_q [NB+1];
  logic [32:0]        rsh    [1:NB];
  logic [31:0]        r_nx   [1:NB];
  logic               b_nx   [1:NB];
  logic [31:0]        num_mag;
  logic [NB-1:0]      qm;
  logic signed [31:0] qres;

  assign num_mag = tcsp_pkg::mag32(num);

  always_comb begin
    for (int s = 1; s <= NB; s++) begin
      rsh[s] = {r_q[s-1], n_q[s-1][NB-1]};
      if (rsh[s] >= {1'b0, d_q[s-1]}) begin
        r_nx[s] = 32'(rsh[s] - {1'b0, d_q[s-1]});
        b_nx[s] = 1'b1;
      end else begin
        r_nx[s] = rsh[s][31:0];
        b_nx[s] = 1'b0;
      end
    end
  end

  always_comb begin
    qm = q_q[NB];
    if (zero_q[NB]) begin
      qres = pass_q[NB];
    end else if (neg_q[NB]) begin
      if (qm > NB'(64'h80000000)) qres = tcsp_pkg::S32_MIN[31:0];
      else qres = 32'(-qm);
    end else begin
      if (qm > NB'(64'h7fffffff)) qres = tcsp_pkg::S32_MAX[31:0];
      else qres = qm[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_q[0]    <= tcsp_pkg::mag32(den);
      r_q[0]    <= '0;
      n_q[0]    <= {num_mag, 16'b0};
      q_q[0]    <= '0;
      neg_q[0]  <= num[31] ^ den[31];
      zero_q[0] <= (den == '0);
      pass_q[0] <= num;
      for (int s = 1; s <= NB; s++) begin
        d_q[s]    <= d_q[s-1];
        r_q[s]    <= r_nx[s];
        n_q[s]    <= n_q[s-1] << 1;
        q_q[s]    <= {q_q[s-1][NB-2:0], b_nx[s]};
        neg_q[s]  <= neg_q[s-1];
        zero_q[s] <= zero_q[s-1];
        pass_q[s] <= pass_q[s-1];
      end
      quo <= qres;
    end
  end
endmodule

@@ design/tcsp_back.sv @@
// back pipeline: shade level, projection with divide by depth, screen mapping
module tcsp_back #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  tcsp_pkg::cfg_t    cfg,
  input  logic              in_valid,
  input  tcsp_pkg::tri_t    in_tri,
  output logic              in_take,
  input  logic              out_full,
  output logic              out_push,
  output tcsp_pkg::result_t out_res
);
  localparam logic signed [63:0] SW = 64'(SCREEN_WIDTH);
  localparam logic signed [63:0] SH = 64'(SCREEN_HEIGHT);
  localparam int LAT = tcsp_pkg::DIV_LAT;

  typedef struct packed {
    logic       valid;
    logic       visible;
    logic [3:0] shade;
  } side_t;

  logic adv;
  logic [3:0] vld;
  logic [3:0] vis;

  logic signed [31:0] tv [3][3];
  logic signed [31:0] tn [3];

  logic signed [47:0] b1_pr [3][3];
  logic signed [31:0] b1_w  [3];
  logic [63:0]        b1_sq [3];
  logic [63:0]        b1_msq;
  logic               b1_nzneg;

  logic signed [31:0] b2_p [3][3];
  logic signed [31:0] b2_w [3];
  logic [63:0]        b2_s;
  logic [71:0]        b2_r;
  logic               b2_nzneg;

  logic signed [31:0] b3_p [3][3];
  logic signed [31:0] b3_w [3];
  logic [71:0]        b3_lhs [1:tcsp_pkg::SHADE_K];
  logic [71:0]        b3_r;
  logic               b3_nzneg;

  logic signed [31:0] b4_p [3][3];
  logic signed [31:0] b4_w [3];
  logic [3:0]         b4_shade;

  logic [3:0]         cnt;
  logic signed [31:0] q [3][3];
  side_t              side [LAT];
  side_t              side_in;
  logic signed [31:0] sx [3], sy [3];
  logic signed [31:0] depth;

  assign adv     = !out_full;
  assign in_take = adv && in_valid;

  always_comb begin
    tv[0][0] = in_tri.v0.x; tv[0][1] = in_tri.v0.y; tv[0][2] = in_tri.v0.z;
    tv[1][0] = in_tri.v1.x; tv[1][1] = in_tri.v1.y; tv[1][2] = in_tri.v1.z;
    tv[2][0] = in_tri.v2.x; tv[2][1] = in_tri.v2.y; tv[2][2] = in_tri.v2.z;
    tn[0] = in_tri.n.x; tn[1] = in_tri.n.y; tn[2] = in_tri.n.z;
  end

  // largest k with k*k*|n|^2 <= 169*nz^2
  always_comb begin
    cnt = '0;
    for (int k = 1; k <= tcsp_pkg::SHADE_K; k++) begin
      cnt = cnt + 4'(b3_lhs[k] <= b3_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vis <= {vis[2:0], in_tri.visible};
      for (int i = 0; i < 3; i++) begin
        b1_pr[i][0] <= tcsp_pkg::qmul(tv[i][0], cfg.proj_x_scale);
        b1_pr[i][1] <= tcsp_pkg::qmul(tv[i][1], cfg.proj_y_scale);
        b1_pr[i][2] <= tcsp_pkg::qmul(tv[i][2], cfg.proj_z_scale);
        b1_w[i]     <= tv[i][2];
        b1_sq[i]    <= 64'(tcsp_pkg::mag32(tn[i])) * 64'(tcsp_pkg::mag32(tn[i]));

        b2_p[i][0] <= tcsp_pkg::sat32(64'(b1_pr[i][0]));
        b2_p[i][1] <= tcsp_pkg::sat32(64'(b1_pr[i][1]));
        b2_p[i][2] <= tcsp_pkg::sat32(64'(b1_pr[i][2]) + 64'(cfg.proj_z_offset));
        b2_w[i]    <= b1_w[i];
        b3_w[i]    <= b2_w[i];
        b4_w[i]    <= b3_w[i];
        for (int j = 0; j < 3; j++) begin
          b3_p[i][j] <= b2_p[i][j];
          b4_p[i][j] <= b3_p[i][j];
        end
      end
      b1_msq   <= 64'(tcsp_pkg::mag32(tn[2])) * 64'(tcsp_pkg::mag32(tn[2]));
      b1_nzneg <= tn[2][31];

      b2_s     <= b1_sq[0] + b1_sq[1] + b1_sq[2];
      b2_r     <= 72'(b1_msq) * 72'd169;
      b2_nzneg <= b1_nzneg;

      for (int k = 1; k <= tcsp_pkg::SHADE_K; k++) begin
        b3_lhs[k] <= 72'(b2_s) * 72'(k * k);
      end
      b3_r     <= b2_r;
      b3_nzneg <= b2_nzneg;

      b4_shade <= (b3_nzneg && cnt <= 4'(tcsp_pkg::SHADE_MAX)) ? cnt : 4'd0;
    end
  end

  for (genvar gi = 0; gi < 3; gi++) begin : g_vert
    for (genvar gj = 0; gj < 3; gj++) begin : g_axis
      tcsp_div u_div (
        .clk (clk),
        .en  (adv),
        .num (b4_p[gi][gj]),
        .den (b4_w[gi]),
        .quo (q[gi][gj])
      );
    end
  end

  assign side_in = '{valid: vld[3], visible: vis[3], shade: b4_shade};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < LAT; s++) begin
        side[s] <= '0;
      end
    end else if (adv) begin
      side[0] <= side_in;
      for (int s = 1; s < LAT; s++) begin
        side[s] <= side[s-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sx[i] = tcsp_pkg::sat32(((64'(q[i][0]) + tcsp_pkg::ONE_Q) * SW) >>> 1);
      sy[i] = tcsp_pkg::sat32(((64'(q[i][1]) + tcsp_pkg::ONE_Q) * SH) >>> 1);
    end
    depth = tcsp_pkg::sat32(64'(q[0][2]) + 64'(q[1][2]) + 64'(q[2][2]));
  end

  assign out_push = adv && side[LAT-1].valid;

  always_comb begin
    out_res = '0;
    if (side[LAT-1].visible) begin
      out_res.visible     = 1'b1;
      out_res.screen0_x   = sx[0];
      out_res.screen0_y   = sy[0];
      out_res.screen1_x   = sx[1];
      out_res.screen1_y   = sy[1];
      out_res.screen2_x   = sx[2];
      out_res.screen2_y   = sy[2];
      out_res.depth_sum   = depth;
      out_res.shade_level = side[LAT-1].shade;
    end
  end
endmodule

@@ design/triangle_transform_cull_shade_project.sv @@
// top level of the triangle transform, cull, shade and project engine
//
//  port group                       direction  word                accepted when
//  push / full / item               in         tcsp_pkg::item_t    push && !full
//  empty / pop / result             out        tcsp_pkg::result_t  pop && !empty
//  cfg_valid / cfg_ready / cfg_*    in         32-bit register     cfg_valid && cfg_ready
//
// one triangle per cycle sustained while neither queue is full; a triangle passes the front pipeline, the middle queue,
// then the shade/scale stages and the divider (48 restoring stages plus capture and output registers)
// and the result queue
// rst is synchronous and restores the register reset values and empties both queues
// a full result queue stalls the back pipeline; a full middle queue stalls the front and raises full
module triangle_transform_cull_shade_project #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  tcsp_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output tcsp_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  tcsp_pkg::cfg_t    cfg;
  tcsp_pkg::tri_t    f_tri, m_tri;
  tcsp_pkg::result_t b_res;
  logic f_ready, f_push, mid_full, mid_empty, b_take, b_push, out_full;

  assign cfg_ready = 1'b1;
  assign full      = !f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= tcsp_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      unique case (tcsp_pkg::cfg_reg_t'(cfg_index))
        tcsp_pkg::REG_ROT_Z_COS:     cfg.rot_z_cos     <= cfg_data;
        tcsp_pkg::REG_ROT_Z_SIN:     cfg.rot_z_sin     <= cfg_data;
        tcsp_pkg::REG_ROT_X_COS:     cfg.rot_x_cos     <= cfg_data;
        tcsp_pkg::REG_ROT_X_SIN:     cfg.rot_x_sin     <= cfg_data;
        tcsp_pkg::REG_PROJ_X_SCALE:  cfg.proj_x_scale  <= cfg_data;
        tcsp_pkg::REG_PROJ_Y_SCALE:  cfg.proj_y_scale  <= cfg_data;
        tcsp_pkg::REG_PROJ_Z_SCALE:  cfg.proj_z_scale  <= cfg_data;
        tcsp_pkg::REG_PROJ_Z_OFFSET: cfg.proj_z_offset <= cfg_data;
      endcase
    end
  end

  tcsp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (push),
    .in_item  (item),
    .ready    (f_ready),
    .out_full (mid_full),
    .out_push (f_push),
    .out_tri  (f_tri)
  );

  tcsp_fifo #(.T(tcsp_pkg::tri_t), .DEPTH(tcsp_pkg::MID_DEPTH)) u_mid (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata (f_tri),
    .full  (mid_full),
    .pop   (b_take),
    .rdata (m_tri),
    .empty (mid_empty)
  );

  tcsp_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (!mid_empty),
    .in_tri   (m_tri),
    .in_take  (b_take),
    .out_full (out_full),
    .out_push (b_push),
    .out_res  (b_res)
  );

  tcsp_fifo #(.T(tcsp_pkg::result_t), .DEPTH(tcsp_pkg::OUT_DEPTH)) u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (b_push),
    .wdata (b_res),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

  a_mid_no_overflow: assert property (@(posedge clk) disable iff (rst)
    f_push |-> !mid_full) else $error("front pushed into a full middle queue");

  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    b_push |-> !out_full) else $error("back pushed into a full result queue");

  a_shade_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.shade_level <= 4'(tcsp_pkg::SHADE_MAX))
    else $error("shade level out of range");

  a_culled_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.visible) |-> (result.depth_sum == '0 && result.shade_level == '0))
    else $error("culled word carries nonzero fields");
endmodule
